[rtl/lcwf_pkg.sv]
// ----------------------------------------------------------------------------
// lcwf_pkg
// Shared types and codes for the LCW format 80 decompressor.
// ----------------------------------------------------------------------------
package lcwf_pkg;

  // Default size of the output history store in bytes.
  localparam int LCWF_HISTORY_DEPTH = 65536;

  // Configuration port geometry.
  localparam int  CFG_ADDR_W   = 3;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [16:0] CAP_RESET = 17'd65536;
  localparam logic [16:0] CAP_MAX   = 17'd65536;

  // Input modes.
  localparam logic [1:0] MODE_FEED  = 2'd0;
  localparam logic [1:0] MODE_PULL  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_NONE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_FULL      = 2'd2;
  localparam logic [1:0] ERR_OFFSET    = 2'd3;

  // Stream status; an error is the error base plus its code.
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_DRAIN = 3'd1;
  localparam logic [2:0] ST_DONE  = 3'd2;

  // Command decoding constants.
  localparam logic [5:0] N_FILL = 6'h3E;
  localparam logic [5:0] N_ABS  = 6'h3F;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_CMD, PH_SHORT_OFF, PH_LITERAL, PH_W0, PH_W1, PH_EXTRA0, PH_EXTRA1
  } phase_t;

  // Kind of the pending run.
  typedef enum logic [1:0] {
    RK_NONE, RK_FILL, RK_REL, RK_ABS
  } run_kind_t;

  // What one accepted word causes on the result side.
  typedef enum logic [2:0] {
    EV_NONE, EV_LIT, EV_PULL, EV_IDLE, EV_DONE, EV_ERR
  } event_t;

  // Channel words.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [16:0] produced_count;
  } out_word_t;

endpackage

[rtl/lcwf_ram.sv]
// ----------------------------------------------------------------------------
// lcwf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lcwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; a read at the written address sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/lcw_format80_decompressor_top.sv]
// ----------------------------------------------------------------------------
// lcw_format80_decompressor_top
// LCW format 80 stream decoder with a byte-wide history RAM.
// ----------------------------------------------------------------------------
// Each word (feed, pull, start or no-op) may be followed by a new word in every
// cycle while the input is not stalled. The result of a word passes through the
// second stage to the output register: at the edge that takes the word the
// history RAM is read into the second stage, and when the second stage advances
// the output register is loaded. The history RAM has one read and one write
// port; a pull that reads the byte written by the word just ahead of it gets
// that byte by forwarding. The RAM is never cleared: bytes are read only below
// the current write position, so a stream start needs no clearing. HISTORY_DEPTH
// must be a power of two. While the output word is stalled, at most one further
// word with a result is held inside, and the input stalls once it is held.
module lcw_format80_decompressor_top
  import lcwf_pkg::*;
#(
  parameter int HISTORY_DEPTH = LCWF_HISTORY_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  // Second stage: a result waiting for its history byte.
  typedef struct packed {
    logic [1:0]    kind;
    logic [1:0]    code;
    logic [16:0]   cnt;
    logic [7:0]    val;
    logic          use_mem;
    logic          fwd;
    logic [AW-1:0] waddr;
  } s1_t;

  // Stream state.
  logic [16:0] wp_r, wp_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] hdr_r, hdr_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] src_r, src_nxt;
  run_kind_t   rk_r, rk_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [16:0] cap_r;
  event_t      ev;

  // Pipeline.
  logic      s1_valid_r;
  s1_t       s1_r, s1_nxt;
  logic [7:0] fwd_val_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      blocked, accept, s1_adv, res_v;
  logic [7:0] s1_byte, mem_rdata;
  logic      mem_we, mem_re;

  // Helpers.
  logic [16:0] cap_now;
  logic        last;
  logic [7:0]  b;
  logic [5:0]  n;
  logic [15:0] hdr_full, rel_cnt, rel_off;
  logic        sticky, pull_mem;

  assign blocked  = out_valid_r && out_stall;
  assign in_stall = s1_valid_r && blocked;
  assign accept   = in_valid && !in_stall;
  assign s1_adv   = !blocked;

  assign cap_now  = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign b        = in_word.data_byte;
  assign last     = in_word.last_byte;
  assign n        = cmd_r[5:0];
  assign hdr_full = {b, hdr_r[7:0]};
  assign sticky   = (st_r[2:1] != 2'b00);
  assign pull_mem = (rk_r != RK_FILL) && (src_r < wp_r);

  // Relative copy parameters for short and long forms.
  always_comb begin
    if (phase_r == PH_SHORT_OFF) begin
      rel_cnt = 16'({1'b0, cmd_r[6:4]}) + 16'd3;
      rel_off = {4'b0, cmd_r[3:0], b};
    end else begin
      rel_cnt = 16'(n) + 16'd3;
      rel_off = hdr_full;
    end
  end

  // Next state of the parser and run registers.
  always_comb begin
    logic       do_fail, do_after, do_rel;
    logic [1:0] fcode;
    wp_nxt    = wp_r;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    hdr_nxt   = hdr_r;
    rem_nxt   = rem_r;
    src_nxt   = src_r;
    rk_nxt    = rk_r;
    fill_nxt  = fill_r;
    st_nxt    = st_r;
    ev        = EV_NONE;
    do_fail   = 1'b0;
    do_after  = 1'b0;
    do_rel    = 1'b0;
    fcode     = ERR_NONE;
    if (accept) begin
      unique case (in_word.mode)
        MODE_FEED: begin
          if (sticky) begin
            ev = (st_r == ST_DONE) ? EV_DONE : EV_ERR;
          end else if (st_r == ST_DRAIN || (rk_r != RK_NONE && rem_r != 16'd0)) begin
            ev = EV_IDLE;
          end else begin
            unique case (phase_r)
              PH_CMD: begin
                cmd_nxt = b;
                rk_nxt  = RK_NONE;
                rem_nxt = 16'd0;
                if (!b[7]) begin
                  if (last) begin
                    do_fail = 1'b1;
                    fcode   = ERR_TRUNCATED;
                  end else begin
                    phase_nxt = PH_SHORT_OFF;
                  end
                end else if (!b[6]) begin
                  if (b[5:0] == 6'd0) begin
                    st_nxt = ST_DONE;
                    ev     = EV_DONE;
                  end else if (last) begin
                    do_fail = 1'b1;
                    fcode   = ERR_TRUNCATED;
                  end else begin
                    rem_nxt   = 16'(b[5:0]);
                    phase_nxt = PH_LITERAL;
                  end
                end else if (last) begin
                  do_fail = 1'b1;
                  fcode   = ERR_TRUNCATED;
                end else begin
                  phase_nxt = PH_W0;
                end
              end
              PH_SHORT_OFF: begin
                do_rel = 1'b1;
              end
              PH_LITERAL: begin
                if (wp_r >= cap_now) begin
                  do_fail = 1'b1;
                  fcode   = ERR_FULL;
                end else begin
                  wp_nxt  = wp_r + 17'd1;
                  rem_nxt = rem_r - 16'd1;
                  ev      = EV_LIT;
                  if (rem_r == 16'd1) begin
                    phase_nxt = PH_CMD;
                    if (last) begin
                      st_nxt = ST_DONE;
                    end
                  end else if (last) begin
                    st_nxt = {1'b1, ERR_TRUNCATED};
                  end
                end
              end
              PH_W0: begin
                hdr_nxt = {8'd0, b};
                if (last) begin
                  do_fail = 1'b1;
                  fcode   = ERR_TRUNCATED;
                end else begin
                  phase_nxt = PH_W1;
                end
              end
              PH_W1: begin
                hdr_nxt = hdr_full;
                if (n != N_FILL && n != N_ABS) begin
                  do_rel = 1'b1;
                end else if (last) begin
                  do_fail = 1'b1;
                  fcode   = ERR_TRUNCATED;
                end else begin
                  rem_nxt   = hdr_full;
                  phase_nxt = PH_EXTRA0;
                end
              end
              PH_EXTRA0: begin
                if (n == N_FILL) begin
                  fill_nxt = b;
                  rk_nxt   = RK_FILL;
                  do_after = 1'b1;
                end else begin
                  hdr_nxt = {8'd0, b};
                  if (last) begin
                    do_fail = 1'b1;
                    fcode   = ERR_TRUNCATED;
                  end else begin
                    phase_nxt = PH_EXTRA1;
                  end
                end
              end
              PH_EXTRA1: begin
                src_nxt  = {1'b0, b, hdr_r[7:0]};
                rk_nxt   = RK_ABS;
                do_after = 1'b1;
              end
              default: begin
                phase_nxt = PH_CMD;
              end
            endcase
          end
        end
        MODE_PULL: begin
          if (sticky) begin
            ev = (st_r == ST_DONE) ? EV_DONE : EV_ERR;
          end else if (rk_r == RK_NONE || rem_r == 16'd0) begin
            ev = EV_IDLE;
          end else if (wp_r >= cap_now || (rk_r == RK_ABS && src_r >= cap_now)) begin
            do_fail = 1'b1;
            fcode   = ERR_FULL;
          end else begin
            ev      = EV_PULL;
            wp_nxt  = wp_r + 17'd1;
            src_nxt = src_r + 17'd1;
            rem_nxt = rem_r - 16'd1;
            if (rem_r == 16'd1) begin
              rk_nxt = RK_NONE;
              if (st_r == ST_DRAIN) begin
                st_nxt = ST_DONE;
              end
            end
          end
        end
        MODE_START: begin
          wp_nxt    = 17'd0;
          phase_nxt = PH_CMD;
          cmd_nxt   = 8'd0;
          hdr_nxt   = 16'd0;
          rem_nxt   = 16'd0;
          src_nxt   = 17'd0;
          rk_nxt    = RK_NONE;
          fill_nxt  = 8'd0;
          st_nxt    = ST_RUN;
        end
        MODE_NOP: begin
        end
        default: begin
        end
      endcase

      // Start of a relative copy or a zero fill.
      if (do_rel) begin
        if (rel_off != 16'd0 && wp_r < {1'b0, rel_off}) begin
          do_fail = 1'b1;
          fcode   = ERR_OFFSET;
        end else begin
          if (rel_off == 16'd0) begin
            rk_nxt   = RK_FILL;
            fill_nxt = 8'd0;
          end else begin
            rk_nxt  = RK_REL;
            src_nxt = wp_r - {1'b0, rel_off};
          end
          rem_nxt  = rel_cnt;
          do_after = 1'b1;
        end
      end

      // Command boundary: a last byte here ends the stream once the run drains.
      if (do_after) begin
        phase_nxt = PH_CMD;
        if (rem_nxt == 16'd0) begin
          rk_nxt = RK_NONE;
        end
        if (last) begin
          if (rk_nxt == RK_NONE) begin
            st_nxt = ST_DONE;
            ev     = EV_DONE;
          end else begin
            st_nxt = ST_DRAIN;
          end
        end
      end

      // Errors end the stream and drop any pending run.
      if (do_fail) begin
        st_nxt  = {1'b1, fcode};
        rk_nxt  = RK_NONE;
        rem_nxt = 16'd0;
        ev      = EV_ERR;
      end
    end
  end

  // Result fields carried into the second stage.
  always_comb begin
    res_v          = 1'b1;
    s1_nxt.kind    = KIND_DATA;
    s1_nxt.code    = ERR_NONE;
    s1_nxt.cnt     = wp_nxt;
    s1_nxt.val     = 8'd0;
    s1_nxt.use_mem = 1'b0;
    s1_nxt.waddr   = wp_r[AW-1:0];
    s1_nxt.fwd     = s1_valid_r && (s1_r.kind == KIND_DATA) &&
                     (s1_r.waddr == src_r[AW-1:0]);
    unique case (ev)
      EV_NONE: res_v = 1'b0;
      EV_LIT:  s1_nxt.val = b;
      EV_PULL: begin
        s1_nxt.val     = (rk_r == RK_FILL) ? fill_r : 8'd0;
        s1_nxt.use_mem = pull_mem;
      end
      EV_IDLE: s1_nxt.kind = KIND_NONE;
      EV_DONE: s1_nxt.kind = KIND_DONE;
      EV_ERR: begin
        s1_nxt.kind = KIND_ERR;
        s1_nxt.code = st_nxt[1:0];
      end
      default: res_v = 1'b0;
    endcase
  end

  // History RAM: read at the copy source, write the byte of the second stage.
  assign mem_re  = accept && (ev == EV_PULL) && pull_mem;
  assign mem_we  = s1_valid_r && s1_adv && (s1_r.kind == KIND_DATA);
  assign s1_byte = s1_r.use_mem ? (s1_r.fwd ? fwd_val_r : mem_rdata) : s1_r.val;

  lcwf_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_r.waddr),
    .wdata (s1_byte),
    .re    (mem_re),
    .raddr (src_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Stream state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 17'd0;
      phase_r <= PH_CMD;
      cmd_r   <= 8'd0;
      hdr_r   <= 16'd0;
      rem_r   <= 16'd0;
      src_r   <= 17'd0;
      rk_r    <= RK_NONE;
      fill_r  <= 8'd0;
      st_r    <= ST_RUN;
    end else begin
      wp_r    <= wp_nxt;
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      hdr_r   <= hdr_nxt;
      rem_r   <= rem_nxt;
      src_r   <= src_nxt;
      rk_r    <= rk_nxt;
      fill_r  <= fill_nxt;
      st_r    <= st_nxt;
    end
  end

  // Configuration register; the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      cap_r <= pwdata[16:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {15'd0, cap_r} : 32'd0;

  // Second stage and output register. An empty second stage takes a word even
  // while the output is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv || !s1_valid_r) begin
        s1_valid_r <= accept && res_v;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      fwd_val_r                 <= s1_byte;
      out_word_r.out_byte       <= s1_byte;
      out_word_r.kind           <= s1_r.kind;
      out_word_r.error_code     <= s1_r.code;
      out_word_r.produced_count <= s1_r.cnt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A held second stage stays held while the output is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && blocked |=> s1_valid_r)
    else $error("second stage lost while output stalled");

  // The input stalls only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with an empty pipeline");

  // The write position never passes the largest capacity.
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= CAP_MAX)
    else $error("write position beyond capacity");

  // A forwarded read is taken at the edge where the RAM writes that byte.
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re && s1_nxt.fwd |-> mem_we)
    else $error("forwarding without a write at the same edge");

  // Only error words carry an error code.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.kind != KIND_ERR |-> out_word_r.error_code == ERR_NONE)
    else $error("error code on a non-error word");

endmodule
